FILE: hw/rtl/wrbt_pkg.sv
// ----------------------------------------------------------------------------
// wrbt_pkg
// Shared types and constants for the windowed rate baseline tracker.
// ----------------------------------------------------------------------------
package wrbt_pkg;

   localparam logic [1:0] MODE_RECORD = 2'd0;
   localparam logic [1:0] MODE_QUERY  = 2'd1;
   localparam logic [1:0] MODE_CLEAR  = 2'd2;
   localparam logic [1:0] MODE_NOP    = 2'd3;

   localparam logic [15:0] FLOOR_RESET   = 16'd3277;
   localparam logic [15:0] CEILING_RESET = 16'd49152;
   localparam logic [15:0] RATIO_ONE     = 16'd16384;

   localparam logic CSR_FLOOR   = 1'b0;
   localparam logic CSR_CEILING = 1'b1;

   // divider: 64-bit dividend, 36-bit divisor, quotient saturated to 32 bits
   localparam int DIV_NUM_W = 64;
   localparam int DIV_DEN_W = 36;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_TOK,
      ST_WAIT_TOK,
      ST_REC_UPD,
      ST_REC_SUB,
      ST_REC_ADD,
      ST_DIV_AVG,
      ST_WAIT_AVG,
      ST_Q_DIV,
      ST_Q_WAIT,
      ST_Q_CLAMP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [15:0] speed_ratio;
      logic [31:0] baseline_time;
      logic [31:0] min_time;
      logic [31:0] max_time;
      logic [4:0]  samples_held;
      logic        skipped;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] elapsed_ms;
      logic [19:0] token_count;
   } req_type;

endpackage

FILE: hw/rtl/wrbt_if.sv
// ----------------------------------------------------------------------------
// wrbt channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface wrbt_req_if;
   logic                 valid;
   logic                 ready;
   wrbt_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wrbt_rsp_if;
   logic                 valid;
   logic                 ready;
   wrbt_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface wrbt_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/wrbt_divider.sv
// ----------------------------------------------------------------------------
// wrbt_divider
// Restoring radix-2 divider, one quotient bit per cycle, 32-bit saturation.
// ----------------------------------------------------------------------------
module wrbt_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [wrbt_pkg::DIV_NUM_W-1:0]      numer,
   input  logic [wrbt_pkg::DIV_DEN_W-1:0]      denom,
   output logic                                done,
   output logic [31:0]                         quot
);
   localparam int NW = wrbt_pkg::DIV_NUM_W;
   localparam int DW = wrbt_pkg::DIV_DEN_W;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] num_ff, num_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [NW-1:0] q_ff, q_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;

   assign trial = {rem_ff[DW-1:0], num_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (!diff[DW]) begin
            rem_in = diff;
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = (|q_ff[NW-1:32]) ? 32'hFFFF_FFFF : q_ff[31:0];
endmodule

FILE: hw/rtl/windowed_rate_baseline_tracker_unit.sv
// ----------------------------------------------------------------------------
// windowed_rate_baseline_tracker_unit
// Per-token time tracker with ring-buffer moving average and ratio query.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | mode, elapsed_ms, token_count
//  rsp     | out | speed_ratio, baseline_time, min_time, max_time, samples_held, skipped
//  csr     | in  | index (0 floor, 1 ceiling), data
//
// One item at a time. A divider pass is a start state, then a wait over the 64
// quotient bits. A record makes two passes (token time, then average); a query
// that divides makes two (token time, ratio) and a clamp. Clear, skip, no-op and
// a query answered 1.0 go straight to the response. The next request is taken in
// the cycle after the response transfer. Reset is synchronous; the ring holds no
// valid bits. A stalled response holds the unit and with it the next request.
module windowed_rate_baseline_tracker_unit #(
   parameter int WINDOW_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   wrbt_req_if.sink   req,
   wrbt_rsp_if.source rsp,
   wrbt_csr_if.sink   csr
);
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int NW = $clog2(WINDOW_DEPTH + 1);
   localparam int SW = 32 + NW;

   wrbt_pkg::state_type state_ff, state_in;
   wrbt_pkg::req_type   item_ff;

   logic [31:0]   ring [WINDOW_DEPTH];
   logic [31:0]   old_ff;
   logic [SW-1:0] sum_ff;
   logic [NW-1:0] cnt_ff;
   logic [AW-1:0] slot_ff;
   logic [31:0]   lo_ff, hi_ff, avg_ff, tok_time_ff;
   logic [15:0]   floor_ff, ceil_ff, ratio_ff;
   logic          skip_ff;

   logic                             div_start;
   logic [wrbt_pkg::DIV_NUM_W-1:0]   div_num;
   logic [wrbt_pkg::DIV_DEN_W-1:0]   div_den;
   logic                             div_done;
   logic [31:0]                      div_q;
   logic                             full;

   assign full = (cnt_ff == NW'(WINDOW_DEPTH));

   wrbt_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_num), .denom(div_den), .done(div_done), .quot(div_q)
   );

   assign req.ready = (state_ff == wrbt_pkg::ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = (state_ff == wrbt_pkg::ST_OUT);
   // all sources are stable while the response waits
   assign rsp.payload = '{speed_ratio:   ratio_ff,
                          baseline_time: avg_ff,
                          min_time:      lo_ff,
                          max_time:      hi_ff,
                          samples_held:  5'(cnt_ff),
                          skipped:       skip_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wrbt_pkg::ST_IDLE: begin
            if (req.valid) begin
               unique case (req.payload.mode)
                  wrbt_pkg::MODE_RECORD:
                     state_in = (req.payload.token_count == '0) ? wrbt_pkg::ST_OUT
                                                                : wrbt_pkg::ST_DIV_TOK;
                  wrbt_pkg::MODE_QUERY:
                     state_in = (req.payload.token_count == '0 || cnt_ff == '0 ||
                                 avg_ff == '0) ? wrbt_pkg::ST_OUT : wrbt_pkg::ST_DIV_TOK;
                  default: state_in = wrbt_pkg::ST_OUT;
               endcase
            end
         end
         wrbt_pkg::ST_DIV_TOK:  state_in = wrbt_pkg::ST_WAIT_TOK;
         wrbt_pkg::ST_WAIT_TOK:
            if (div_done)
               state_in = (item_ff.mode == wrbt_pkg::MODE_QUERY) ? wrbt_pkg::ST_Q_DIV
                                                                 : wrbt_pkg::ST_REC_UPD;
         wrbt_pkg::ST_REC_UPD:  state_in = wrbt_pkg::ST_REC_SUB;
         wrbt_pkg::ST_REC_SUB:  state_in = wrbt_pkg::ST_REC_ADD;
         wrbt_pkg::ST_REC_ADD:  state_in = wrbt_pkg::ST_DIV_AVG;
         wrbt_pkg::ST_DIV_AVG:  state_in = wrbt_pkg::ST_WAIT_AVG;
         wrbt_pkg::ST_WAIT_AVG: if (div_done) state_in = wrbt_pkg::ST_OUT;
         wrbt_pkg::ST_Q_DIV:    state_in = wrbt_pkg::ST_Q_WAIT;
         wrbt_pkg::ST_Q_WAIT:   if (div_done) state_in = wrbt_pkg::ST_Q_CLAMP;
         wrbt_pkg::ST_Q_CLAMP:  state_in = wrbt_pkg::ST_OUT;
         wrbt_pkg::ST_OUT:      if (rsp.ready) state_in = wrbt_pkg::ST_IDLE;
         default:               state_in = wrbt_pkg::ST_IDLE;
      endcase
   end

   // divider operand select
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      unique case (state_ff)
         wrbt_pkg::ST_DIV_TOK: begin
            div_start = 1'b1;
            div_num   = {24'd0, item_ff.elapsed_ms, 16'd0};
            div_den   = {16'd0, item_ff.token_count};
         end
         wrbt_pkg::ST_DIV_AVG: begin
            div_start = 1'b1;
            div_num   = wrbt_pkg::DIV_NUM_W'(sum_ff);
            div_den   = wrbt_pkg::DIV_DEN_W'(cnt_ff);
         end
         wrbt_pkg::ST_Q_DIV: begin
            div_start = 1'b1;
            div_num   = {18'd0, tok_time_ff, 14'd0};
            div_den   = {4'd0, avg_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wrbt_pkg::ST_IDLE;
         floor_ff <= wrbt_pkg::FLOOR_RESET;
         ceil_ff  <= wrbt_pkg::CEILING_RESET;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         slot_ff  <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         avg_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr.valid) begin
            if (csr.index == wrbt_pkg::CSR_FLOOR) floor_ff <= csr.data;
            else                                  ceil_ff  <= csr.data;
         end
         unique case (state_ff)
            wrbt_pkg::ST_IDLE:
               if (req.valid && req.payload.mode == wrbt_pkg::MODE_CLEAR) begin
                  sum_ff  <= '0;
                  cnt_ff  <= '0;
                  slot_ff <= '0;
                  lo_ff   <= '0;
                  hi_ff   <= '0;
                  avg_ff  <= '0;
               end
            wrbt_pkg::ST_REC_UPD: begin
               if (cnt_ff == '0) begin
                  lo_ff <= tok_time_ff;
                  hi_ff <= tok_time_ff;
               end else begin
                  if (tok_time_ff < lo_ff) lo_ff <= tok_time_ff;
                  if (tok_time_ff > hi_ff) hi_ff <= tok_time_ff;
               end
            end
            wrbt_pkg::ST_REC_SUB:
               if (full) sum_ff <= sum_ff - SW'(old_ff);
            wrbt_pkg::ST_REC_ADD: begin
               sum_ff  <= sum_ff + SW'(tok_time_ff);
               slot_ff <= (slot_ff == AW'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (!full) cnt_ff <= cnt_ff + 1'b1;
            end
            wrbt_pkg::ST_WAIT_AVG:
               if (div_done) avg_ff <= div_q;
            default: ;
         endcase
      end
   end

   // ring memory: read old entry, then overwrite
   always_ff @(posedge clock) begin
      if (state_ff == wrbt_pkg::ST_REC_UPD) old_ff <= ring[slot_ff];
      if (state_ff == wrbt_pkg::ST_REC_ADD) ring[slot_ff] <= tok_time_ff;
   end

   // payload path
   always_ff @(posedge clock) begin
      if (state_ff == wrbt_pkg::ST_IDLE && req.valid) begin
         item_ff  <= req.payload;
         skip_ff  <= (req.payload.mode == wrbt_pkg::MODE_RECORD &&
                      req.payload.token_count == '0);
         ratio_ff <= (req.payload.mode == wrbt_pkg::MODE_QUERY) ? wrbt_pkg::RATIO_ONE : '0;
      end
      if (state_ff == wrbt_pkg::ST_WAIT_TOK && div_done) tok_time_ff <= div_q;
      if (state_ff == wrbt_pkg::ST_Q_WAIT && div_done) begin
         if (div_q < 32'(floor_ff))      ratio_ff <= floor_ff;
         else if (div_q > 32'(ceil_ff))  ratio_ff <= ceil_ff;
         else                            ratio_ff <= div_q[15:0];
      end
   end
endmodule
